// ===== rtl/pstm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_pkg
// Shared codes, widths and types for the tolerance-box point matcher.
// ----------------------------------------------------------------------------
package pstm_pkg;

    localparam int TOL_W      = 8;
    localparam int INDEX_BITS = 10;
    localparam int OP_W       = 2;
    localparam int CLS_W      = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd2;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // item classes passed from the front to the back
    localparam logic [CLS_W-1:0] CLS_NOP   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_CLEAR = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ADD   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_QUERY = 2'd3;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// ===== rtl/pstm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_front
// Accepts input transactions, classifies the operation and hands the item
// to the queue from a holding register.
// ----------------------------------------------------------------------------
module pstm_front
    import pstm_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int ITEM_W     = CLS_W + 2 * COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [OP_W-1:0]              i_operation,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  t_q_status                    i_q_status,
    output logic                         o_push,
    output logic [ITEM_W-1:0]            o_item
);

    logic                  r_valid;
    logic [CLS_W-1:0]      r_cls;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [CLS_W-1:0]      n_cls;
    logic                  accept;

    always_comb begin
        case (i_operation)
            OP_CLEAR: n_cls = CLS_CLEAR;
            OP_ADD:   n_cls = CLS_ADD;
            OP_QUERY: n_cls = CLS_QUERY;
            default:  n_cls = CLS_NOP;
        endcase
    end

    assign o_push  = r_valid && !i_q_status.full;
    assign o_stall = r_valid && i_q_status.full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = {r_cls, r_x, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
            r_x   <= i_point_x;
            r_y   <= i_point_y;
        end
    end

endmodule

// ===== rtl/pstm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pstm_queue
    import pstm_pkg::*;
#(
    parameter int ITEM_W = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [ITEM_W-1:0] i_item,
    input  logic              i_pop,
    output logic [ITEM_W-1:0] o_item,
    output t_q_status         o_status
);

    logic [ITEM_W-1:0] r_entry [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_status.full      = (r_fill == 2'd2);
    assign o_status.not_empty = (r_fill != 2'd0);
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_item             = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/pstm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_back
// Executes clear, add and query against the reference point memory and
// holds the result register. A query scans one stored point per cycle.
// ----------------------------------------------------------------------------
module pstm_back
    import pstm_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 14,
    parameter int ITEM_W     = CLS_W + 2 * COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [TOL_W-1:0]             i_cfg_data,
    input  t_q_status                    i_q_status,
    input  logic [ITEM_W-1:0]            i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_status,
    output logic                         o_matched,
    output logic [INDEX_BITS-1:0]        o_match_index,
    output logic signed [COORD_BITS-1:0] o_echo_x,
    output logic signed [COORD_BITS-1:0] o_echo_y
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int DW    = COORD_BITS + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  r_state;
    logic [CNT_W-1:0]      r_count;
    logic [TOL_W-1:0]      r_tol;
    logic                  r_issue;
    logic                  r_cmp_valid;
    logic [AW-1:0]         r_cmp_idx;
    logic [AW-1:0]         r_addr;
    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;
    logic [PT_W-1:0]       r_rd_data;
    logic [PT_W-1:0]       r_ref_mem [MAX_POINTS];

    logic                  r_o_valid;
    logic                  r_o_status;
    logic                  r_o_matched;
    logic [INDEX_BITS-1:0] r_o_index;
    logic [COORD_BITS-1:0] r_o_x;
    logic [COORD_BITS-1:0] r_o_y;

    logic [CLS_W-1:0]           it_cls;
    logic [COORD_BITS-1:0]      it_x;
    logic [COORD_BITS-1:0]      it_y;
    logic                       out_free;
    logic                       has_room;
    logic                       wr_en;
    logic                       issue;
    logic [AW-1:0]              last_addr;
    logic signed [DW-1:0]       dx;
    logic signed [DW-1:0]       dy;
    logic [DW-1:0]              adx;
    logic [DW-1:0]              ady;
    logic                       hit;
    logic                       cmp_end;
    logic [INDEX_BITS+AW-1:0]   idx_ext;

    assign {it_cls, it_x, it_y} = i_item;
    assign out_free  = !r_o_valid || !i_stall;
    assign o_pop     = i_q_status.not_empty && (r_state == S_IDLE) && out_free;
    assign has_room  = (r_count < CNT_W'(MAX_POINTS));
    assign wr_en     = o_pop && (it_cls == CLS_ADD) && has_room;
    assign issue     = (r_state == S_SCAN) && r_issue;
    assign last_addr = AW'(r_count - CNT_W'(1));

    always_comb begin
        dx  = DW'(signed'(r_qx)) - DW'(signed'(r_rd_data[PT_W-1:COORD_BITS]));
        dy  = DW'(signed'(r_qy)) - DW'(signed'(r_rd_data[COORD_BITS-1:0]));
        adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        hit = (adx < DW'(r_tol)) && (ady < DW'(r_tol));
    end

    assign cmp_end = r_cmp_valid && (hit || (r_cmp_idx == last_addr));
    assign idx_ext = {{INDEX_BITS{1'b0}}, r_cmp_idx};

    // point memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ref_mem[r_count[AW-1:0]] <= {it_x, it_y};
        end
        r_rd_data <= r_ref_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tol       <= TOL_RESET;
            r_issue     <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            r_cmp_valid <= issue && !cmp_end;
            if (issue && (r_addr == last_addr)) begin
                r_issue <= 1'b0;
            end
            if (cmp_end) begin
                r_state   <= S_IDLE;
                r_issue   <= 1'b0;
                r_o_valid <= 1'b1;
            end
            if (o_pop) begin
                case (it_cls)
                    CLS_CLEAR: begin
                        r_count   <= '0;
                        r_o_valid <= 1'b1;
                    end
                    CLS_ADD: begin
                        if (has_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_o_valid <= 1'b1;
                    end
                    CLS_QUERY: begin
                        if (r_count == '0) begin
                            r_o_valid <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                            r_issue <= 1'b1;
                        end
                    end
                    default: begin
                        r_o_valid <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_addr <= r_addr + AW'(1);
        end
        r_cmp_idx <= r_addr;
        if (cmp_end) begin
            r_o_status  <= 1'b0;
            r_o_matched <= hit;
            r_o_index   <= hit ? idx_ext[INDEX_BITS-1:0] : '0;
            r_o_x       <= r_qx;
            r_o_y       <= r_qy;
        end
        if (o_pop) begin
            r_addr      <= '0;
            r_qx        <= it_x;
            r_qy        <= it_y;
            r_o_status  <= (it_cls == CLS_ADD) && !has_room;
            r_o_matched <= 1'b0;
            r_o_index   <= '0;
            r_o_x       <= it_x;
            r_o_y       <= it_y;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_matched     = r_o_matched;
    assign o_match_index = r_o_index;
    assign o_echo_x      = r_o_x;
    assign o_echo_y      = r_o_y;

endmodule

// ===== rtl/point_set_tolerance_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_tolerance_matcher_top
// Reference point set with clear, add and tolerance-box query.
// ----------------------------------------------------------------------------
// One result per input transaction, in order. Clear, add and an unused
// operation complete when taken from the queue; a query against N stored
// points scans them in the execution stage (first match ends it early),
// as the single read port of the point memory delivers one stored point
// per cycle. Input items pass a holding register and a two-entry queue
// first, so the input side keeps accepting while a query scans, until both
// are full. The point memory is not cleared: only entries below the stored
// count are read. Tolerance may be written only while the block is idle.
// ----------------------------------------------------------------------------
module point_set_tolerance_matcher_top
    import pstm_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [OP_W-1:0]              i_operation,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_status,
    output logic                         o_matched,
    output logic [INDEX_BITS-1:0]        o_match_index,
    output logic signed [COORD_BITS-1:0] o_echo_x,
    output logic signed [COORD_BITS-1:0] o_echo_y,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [TOL_W-1:0]             i_cfg_data
);

    localparam int ITEM_W = CLS_W + 2 * COORD_BITS;

    t_q_status         q_status;
    logic              push;
    logic              pop;
    logic [ITEM_W-1:0] push_item;
    logic [ITEM_W-1:0] pop_item;

    assign o_cfg_ready = 1'b1;

    pstm_front #(
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    pstm_queue #(
        .ITEM_W (ITEM_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    pstm_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (q_status),
        .i_item        (pop_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_matched     (o_matched),
        .o_match_index (o_match_index),
        .o_echo_x      (o_echo_x),
        .o_echo_y      (o_echo_y)
    );

endmodule

// ===== rtl/pstm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_checker
// Port-level checks on the matcher outputs, bound to the top level.
// ----------------------------------------------------------------------------
module pstm_checker
    import pstm_pkg::*;
#(
    parameter int COORD_BITS = 14
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_status,
    input logic                         o_matched,
    input logic [INDEX_BITS-1:0]        o_match_index,
    input logic signed [COORD_BITS-1:0] o_echo_x,
    input logic signed [COORD_BITS-1:0] o_echo_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_index)
            && $stable(o_echo_x) && $stable(o_echo_y))
        else $error("stalled result changed");

    a_full_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_matched && (o_match_index == '0))
        else $error("dropped add reports a match");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_matched |-> (o_match_index == '0))
        else $error("miss with nonzero index");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind point_set_tolerance_matcher_top pstm_checker #(
    .COORD_BITS (COORD_BITS)
) u_pstm_checker (.*);

// ===== bench/point_set_tolerance_matcher_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_tolerance_matcher_top_test
// Self-checking bench for the tolerance-box point matcher.
// ----------------------------------------------------------------------------
// Drives clear, add and query transactions and compares every result with a
// predictor that keeps its own copy of the stored point set and tolerance.
// A directed opening covers the coordinate extremes, each operation, the
// unused operation code, empty and cleared sets and tolerance boundaries.
// The random part sends add/query sequences aimed near stored points, with
// noise, over several tolerance settings (zero, one and the maximum among
// them), with random idling on both channels and a quiet stretch at the end.
// ----------------------------------------------------------------------------
module point_set_tolerance_matcher_top_test;
    import pstm_pkg::*;

    localparam int COORD_W        = 14;
    localparam int STORE_DEPTH    = 1024;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int CFG_SETTLE     = 8;
    localparam int END_SETTLE     = 32;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        logic                  status;
        logic                  matched;
        logic [INDEX_BITS-1:0] match_index;
        t_coord                echo_x;
        t_coord                echo_y;
    } t_match_result;

    class point_match_tracker;
        int            tolerance = TOL_RESET;
        int            point_count = 0;
        int            xs [STORE_DEPTH];
        int            ys [STORE_DEPTH];
        t_match_result pending_matches [$];
        int            mismatch_count = 0;

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        function void note_transaction(logic [OP_W-1:0] op, t_coord px, t_coord py);
            t_match_result r;
            int            dx;
            int            dy;
            r.status      = 1'b0;
            r.matched     = 1'b0;
            r.match_index = '0;
            r.echo_x      = px;
            r.echo_y      = py;
            case (op)
                OP_CLEAR: begin
                    point_count = 0;
                end
                OP_ADD: begin
                    if (point_count < STORE_DEPTH) begin
                        xs[point_count] = int'(px);
                        ys[point_count] = int'(py);
                        point_count++;
                    end else begin
                        r.status = 1'b1;
                    end
                end
                OP_QUERY: begin
                    for (int i = 0; i < point_count && !r.matched; i++) begin
                        dx = int'(px) - xs[i];
                        dy = int'(py) - ys[i];
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (dx < tolerance && dy < tolerance) begin
                            r.matched     = 1'b1;
                            r.match_index = i[INDEX_BITS-1:0];
                        end
                    end
                end
                default: ;
            endcase
            pending_matches.insert(pending_matches.size(), r);
        endfunction

        task check_result(logic status, logic matched, logic [INDEX_BITS-1:0] idx,
                          t_coord ex, t_coord ey);
            t_match_result e;
            if (pending_matches.size() == 0) begin
                report("result with no transaction pending");
            end else begin
                e = pending_matches.pop_front();
                if (status !== e.status)
                    report($sformatf("status got %b expected %b", status, e.status));
                if (matched !== e.matched)
                    report($sformatf("matched got %b expected %b", matched, e.matched));
                if (idx !== e.match_index)
                    report($sformatf("match_index got %0d expected %0d",
                                     idx, e.match_index));
                if (ex !== e.echo_x)
                    report($sformatf("echo_x got %0d expected %0d", ex, e.echo_x));
                if (ey !== e.echo_y)
                    report($sformatf("echo_y got %0d expected %0d", ey, e.echo_y));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OP_W-1:0]       i_operation;
    t_coord                i_point_x;
    t_coord                i_point_y;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_status;
    logic                  o_matched;
    logic [INDEX_BITS-1:0] o_match_index;
    t_coord                o_echo_x;
    t_coord                o_echo_y;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [TOL_W-1:0]      i_cfg_data;

    point_match_tracker sb;
    bit                 calm = 1'b0;
    int                 items_sent = 0;
    int                 gap_free = 0;
    int                 quiet = 0;

    point_set_tolerance_matcher_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_matched    (o_matched),
        .o_match_index(o_match_index),
        .o_echo_x     (o_echo_x),
        .o_echo_y     (o_echo_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_matched, o_match_index, o_echo_x, o_echo_y);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            quiet <= 0;
        else if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                 (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        wait (quiet >= WATCHDOG_LIMIT);
        $display("point_set_tolerance_matcher_top_test: done, errors");
        $finish;
    end

    initial begin
        int n;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_stall <= 1'b1;
                        n = $urandom_range(1, 16);
                    end
                    3: begin
                        i_stall <= 1'b0;
                        n = $urandom_range(20, 60);
                    end
                    default: begin
                        i_stall <= 1'b0;
                        n = $urandom_range(1, 16);
                    end
                endcase
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, t_coord px, t_coord py);
        if (gap_free > 0) begin
            gap_free--;
        end else if (!calm) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end
                2: gap_free = $urandom_range(20, 50);
                default: ;
            endcase
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_point_x   <= px;
        i_point_y   <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_transaction(op, px, py);
        items_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_matches.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        drain_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.tolerance = value;
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 11))
            0: return -14'sd8192;
            1: return 14'sd8191;
            2: return -14'sd1;
            3: return '0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_coord near_coord(int base);
        int off;
        off = int'($urandom_range(0, 2 * sb.tolerance)) - sb.tolerance;
        return t_coord'(base + off);
    endfunction

    task automatic run_random(int count);
        int start;
        int adds;
        int queries;
        int pick;
        bit drained;
        start   = items_sent;
        drained = 1'b0;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_CLEAR, rand_coord(), rand_coord());
                adds = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200)
                                                    : $urandom_range(1, 12);
                repeat (adds) send_item(OP_ADD, rand_coord(), rand_coord());
                queries = $urandom_range(1, 10);
                repeat (queries) begin
                    if (sb.point_count > 0 && $urandom_range(0, 3) != 0) begin
                        pick = $urandom_range(0, sb.point_count - 1);
                        send_item(OP_QUERY, near_coord(sb.xs[pick]),
                                  near_coord(sb.ys[pick]));
                    end else begin
                        send_item(OP_QUERY, rand_coord(), rand_coord());
                    end
                end
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(OP_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
            end
            if ((!drained && items_sent - start >= count / 2) ||
                (!calm && $urandom_range(0, 19) == 0)) begin
                drain_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_CLEAR;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= TOL_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset tolerance, extremes and special cases
        send_item(OP_QUERY, 0, 0);
        send_item(OP_UNUSED, -8192, 8191);
        send_item(OP_ADD, -8192, -8192);
        send_item(OP_ADD, 8191, 8191);
        send_item(OP_ADD, 0, 0);
        send_item(OP_ADD, 1, -1);
        send_item(OP_QUERY, -8191, -8192);
        send_item(OP_QUERY, 8189, 8191);
        send_item(OP_QUERY, 8190, 8190);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_QUERY, 2, -2);
        send_item(OP_UNUSED, 0, 0);
        send_item(OP_ADD, -1, 8191);
        send_item(OP_QUERY, 8191, -8192);
        send_item(OP_QUERY, 0, 8190);
        send_item(OP_CLEAR, 8191, -8192);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ADD, 5, 5);
        send_item(OP_QUERY, 5, 5);
        send_item(OP_QUERY, -8192, -8192);

        write_tolerance(8'd1);
        send_item(OP_QUERY, 5, 5);
        send_item(OP_QUERY, 6, 5);
        run_random(120);

        write_tolerance(8'd255);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_ADD, 0, 0);
        send_item(OP_QUERY, 254, -254);
        send_item(OP_QUERY, 255, 0);
        run_random(100);

        write_tolerance(8'd0);
        send_item(OP_QUERY, 0, 0);
        run_random(50);

        write_tolerance(8'd4);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_ADD, 7, 7);
        send_item(OP_QUERY, 7, 10);
        send_item(OP_QUERY, 7, 11);

        write_tolerance(TOL_W'($urandom_range(2, 40)));
        run_random(170);
        calm = 1'b1;
        run_random(60);

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (sb.pending_matches.size() != 0)
            sb.report("results missing at end of run");
        if (sb.mismatch_count == 0)
            $display("point_set_tolerance_matcher_top_test: done, clean");
        else
            $display("point_set_tolerance_matcher_top_test: done, errors");
        $finish;
    end

endmodule
